// ----- sv/gas_pkg.sv -----
`timescale 1ns / 1ps

package gas_pkg;

  // Sizes of the grid, the node store and the open queue.
  localparam int MAX_DIM     = 64;
  localparam int MAX_CELLS   = 4096;
  localparam int QUEUE_DEPTH = 4096;

  // Field widths fixed by the interface.
  localparam int DIM_W   = 7;
  localparam int COORD_W = 6;
  localparam int CELL_W  = $clog2(MAX_CELLS);
  localparam int LEN_W   = CELL_W + 1;
  localparam int LIM_W   = 2 * DIM_W;
  localparam int COST_W  = 24;
  localparam int ROOT_W  = 16;
  localparam int QIDX_W  = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W  = QIDX_W + 1;

  localparam logic [COST_W-1:0] COST_MAX      = '1;
  localparam logic [COST_W-1:0] STEP_STRAIGHT = 24'd256;
  localparam logic [COST_W-1:0] STEP_DIAG     = 24'd362;

  // Command codes.
  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_SEARCH = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  // Status codes.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_SAME     = 3'd1;
  localparam logic [2:0] ST_GRID     = 3'd2;
  localparam logic [2:0] ST_NO_PATH  = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;
  localparam logic [2:0] ST_BAD_POS  = 3'd5;

  // Configuration register indexes.
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
    logic               blocked;
    logic [COORD_W-1:0] goal_x;
    logic [COORD_W-1:0] goal_y;
    logic [CELL_W-1:0]  path_pos;
  } gas_req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [LEN_W-1:0]   path_length;
    logic [COORD_W-1:0] path_x;
    logic [COORD_W-1:0] path_y;
  } gas_rsp_t;

  // Queue key: priority first, so a plain compare breaks ties on the index.
  typedef struct packed {
    logic [COST_W-1:0] prio;
    logic [CELL_W-1:0] idx;
  } gas_key_t;

  typedef struct packed {
    logic     push;
    logic     pop;
    logic     clear;
    gas_key_t key;
  } gas_heap_req_t;

  typedef struct packed {
    logic              busy;
    logic [QCNT_W-1:0] count;
    gas_key_t          top;
  } gas_heap_rsp_t;

  typedef struct packed {
    logic               valid;
    logic [COST_W-1:0]  cost;
    logic [CELL_W-1:0]  parent;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } gas_node_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } gas_point_t;

  typedef enum logic [3:0] {
    H_IDLE, H_UP_LOOP, H_UP_CMP, H_DN_TOP, H_DN_LAST,
    H_DN_LOOP, H_DN_CHILD, H_DN_SIB, H_DN_MOVE, H_DN_FIN
  } gas_heap_state_t;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_READ, S_NCLR, S_SEED, S_ROOT_WAIT, S_POP, S_POP_WAIT,
    S_UREAD, S_NB, S_NB_CHK, S_H_WAIT, S_PUSH_WAIT, S_PATH, S_PATH_RD, S_RESULT
  } gas_state_t;

endpackage

// ----- sv/grid_astar_path_search.sv -----
`timescale 1ns / 1ps

// Grid A* path search. A load word writes one cell of the obstacle map; a
// read word returns one stored path entry (goal first). A search word first
// sweeps the 4096-entry node store, one entry a cycle, then runs the search:
// each expansion takes a heap pop plus, for each of the eight neighbours inside
// the grid, a read of the node and obstacle memories and, where the neighbour
// improves and is not the goal, a square root for the goal distance and a heap
// push. Path readout reads the parent from the node store for each cell. After
// reset the 4096-entry obstacle map is cleared, during which no word is taken;
// configuration writes are taken at any time.
module grid_astar_path_search
  import gas_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  gas_req_t         req_word,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output gas_rsp_t         rsp_word,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [DIM_W-1:0] cfg_data
);

  function automatic logic [COORD_W-1:0] absd(input logic [COORD_W-1:0] a,
                                               input logic [COORD_W-1:0] b);
    absd = (a > b) ? a - b : b - a;
  endfunction

  function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                 input logic [COST_W-1:0] b);
    logic [COST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add = s[COST_W] ? COST_MAX : s[COST_W-1:0];
  endfunction

  gas_state_t state, state_next;

  // Configuration and clamped geometry.
  logic [DIM_W-1:0] grid_width, grid_height, w_use, h_use;
  logic [LIM_W-1:0] lim_full, lim;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= DIM_W'(MAX_DIM);
      grid_height <= DIM_W'(MAX_DIM);
    end else if (cfg_we) begin
      if (cfg_index == REG_WIDTH) grid_width <= cfg_data;
      if (cfg_index == REG_HEIGHT) grid_height <= cfg_data;
    end
  end

  assign w_use = (grid_width == '0) ? DIM_W'(1) :
                 (grid_width > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : grid_width;
  assign h_use = (grid_height == '0) ? DIM_W'(1) :
                 (grid_height > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : grid_height;
  assign lim_full = w_use * h_use;
  assign lim = (lim_full > LIM_W'(MAX_CELLS)) ? LIM_W'(MAX_CELLS) : lim_full;

  // Memories: obstacle map, node store, path buffer.
  logic              obst_mem [MAX_CELLS];
  gas_node_t         node_mem [MAX_CELLS];
  gas_point_t        path_mem [MAX_CELLS];
  logic              obst_we, obst_wdata, obst_rdata;
  logic [CELL_W-1:0] obst_waddr, node_waddr, node_raddr, path_waddr, path_raddr;
  logic [CELL_W-1:0] nb_raddr;
  logic              node_we, path_we;
  gas_node_t         node_wdata, node_rdata;
  gas_point_t        path_wdata, path_rdata;

  always_ff @(posedge clk) begin
    if (obst_we) obst_mem[obst_waddr] <= obst_wdata;
    obst_rdata <= obst_mem[nb_raddr];
  end

  always_ff @(posedge clk) begin
    if (node_we) node_mem[node_waddr] <= node_wdata;
    node_rdata <= node_mem[node_raddr];
  end

  always_ff @(posedge clk) begin
    if (path_we) path_mem[path_waddr] <= path_wdata;
    path_rdata <= path_mem[path_raddr];
  end

  // Working registers.
  logic [CELL_W-1:0]  clr_idx, s_cell, g_cell, u_cell, v_cell, p_cell, p_par, plen;
  logic [COORD_W-1:0] sx, sy, gx, gy, ux, uy, vx, vy, px, py;
  logic [COST_W-1:0]  u_cost;
  logic [2:0]         k;
  logic [LEN_W-1:0]   stored_length;
  gas_rsp_t           res;

  // Decode of the incoming word.
  logic              accept, slot_free;
  logic [LIM_W-1:0]  ld_addr, s_addr, g_addr;
  logic              ld_in, out_grid;

  assign accept    = req_valid && !req_stall;
  assign slot_free = !rsp_valid || !rsp_stall;
  assign req_stall = (state != S_IDLE);

  assign ld_addr = LIM_W'(req_word.cell_x) + LIM_W'(req_word.cell_y) * LIM_W'(w_use);
  assign s_addr  = ld_addr;
  assign g_addr  = LIM_W'(req_word.goal_x) + LIM_W'(req_word.goal_y) * LIM_W'(w_use);
  assign ld_in   = (DIM_W'(req_word.cell_x) < w_use) && (DIM_W'(req_word.cell_y) < h_use) &&
                   (ld_addr < LIM_W'(MAX_CELLS));
  assign out_grid = (DIM_W'(req_word.cell_x) >= w_use) || (DIM_W'(req_word.cell_y) >= h_use) ||
                    (DIM_W'(req_word.goal_x) >= w_use) || (DIM_W'(req_word.goal_y) >= h_use) ||
                    (s_addr >= lim) || (g_addr >= lim);

  // Result word for the incoming command, as it stands before any search.
  gas_rsp_t res_new;

  always_comb begin
    res_new = '{status: ST_OK, path_length: stored_length, path_x: '0, path_y: '0};
    case (req_word.cmd)
      CMD_LOAD: if (!ld_in) res_new.status = ST_GRID;
      CMD_SEARCH: begin
        res_new.path_length = '0;
        if (out_grid) begin
          res_new.status = ST_GRID;
        end else if (s_addr == g_addr) begin
          res_new.status      = ST_SAME;
          res_new.path_length = LEN_W'(1);
        end
      end
      CMD_READ: begin
        if ({1'b0, req_word.path_pos} >= stored_length) res_new.status = ST_BAD_POS;
      end
      default: ;
    endcase
  end

  // Neighbour offset, wrap flags and bounds for direction k.
  logic signed [14:0] ws, e, vs;
  logic [COORD_W-1:0] dxk, dyk;
  logic               is_right, is_left, nb_skip;
  logic [COST_W-1:0]  nc, step;

  assign ws = $signed({8'd0, w_use});

  always_comb begin
    case (k)
      3'd0: begin e = -ws - 15'sd1; dxk = '1; dyk = '1; end
      3'd1: begin e = -ws + 15'sd1; dxk = 6'd1; dyk = '1; end
      3'd2: begin e = ws - 15'sd1; dxk = '1; dyk = 6'd1; end
      3'd3: begin e = ws + 15'sd1; dxk = 6'd1; dyk = 6'd1; end
      3'd4: begin e = 15'sd1; dxk = 6'd1; dyk = '0; end
      3'd5: begin e = -15'sd1; dxk = '1; dyk = '0; end
      3'd6: begin e = ws; dxk = '0; dyk = 6'd1; end
      default: begin e = -ws; dxk = '0; dyk = '1; end
    endcase
  end

  assign is_right = (e == 15'sd1) || (e == 15'sd1 - ws) || (e == ws + 15'sd1);
  assign is_left  = (e == -15'sd1) || (e == -ws - 15'sd1) || (e == ws - 15'sd1);
  assign vs       = $signed({3'd0, u_cell}) + e;
  assign nb_skip  = (is_right && ({1'b0, ux} == w_use - 1'b1)) || (is_left && ux == '0) ||
                    (vs < 15'sd0) || (vs >= $signed({1'b0, lim}));
  assign nb_raddr = vs[CELL_W-1:0];
  assign step     = k[2] ? STEP_STRAIGHT : STEP_DIAG;
  assign nc       = sat_add(u_cost, step);

  logic relax;
  assign relax = !obst_rdata && (!node_rdata.valid || node_rdata.cost > nc);

  // Square root unit and open queue.
  logic               root_start, root_done;
  logic [COORD_W-1:0] root_dx, root_dy;
  logic [ROOT_W-1:0]  root;
  gas_heap_req_t      hreq;
  gas_heap_rsp_t      hrsp;
  logic               q_full;

  assign q_full = (hrsp.count >= QCNT_W'(QUEUE_DEPTH));

  gas_isqrt u_isqrt (
    .clk  (clk),
    .rst  (rst),
    .start(root_start),
    .dx   (root_dx),
    .dy   (root_dy),
    .done (root_done),
    .root (root)
  );

  gas_heap u_heap (
    .clk(clk),
    .rst(rst),
    .req(hreq),
    .rsp(hrsp)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_CLR: if (&clr_idx) state_next = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          if (req_word.cmd == CMD_SEARCH && !out_grid && s_addr != g_addr)
            state_next = S_NCLR;
          else if (req_word.cmd == CMD_READ &&
                   {1'b0, req_word.path_pos} < stored_length)
            state_next = S_READ;
          else
            state_next = S_RESULT;
        end
      end
      S_READ:      state_next = S_RESULT;
      S_NCLR:      if (&clr_idx) state_next = S_SEED;
      S_SEED:      state_next = S_ROOT_WAIT;
      S_ROOT_WAIT: if (root_done) state_next = S_POP;
      S_POP: begin
        if (!hrsp.busy) state_next = (hrsp.count == '0) ? S_RESULT : S_POP_WAIT;
      end
      S_POP_WAIT:  if (!hrsp.busy) state_next = S_UREAD;
      S_UREAD:     state_next = S_NB;
      S_NB: begin
        if (!nb_skip) state_next = S_NB_CHK;
        else if (k == 3'd7) state_next = S_POP;
      end
      S_NB_CHK: begin
        if (!relax) state_next = (k == 3'd7) ? S_POP : S_NB;
        else if (v_cell == g_cell) state_next = S_PATH;
        else if (q_full) state_next = S_RESULT;
        else state_next = S_H_WAIT;
      end
      S_H_WAIT:    if (root_done) state_next = S_PUSH_WAIT;
      S_PUSH_WAIT: if (!hrsp.busy) state_next = (k == 3'd7) ? S_POP : S_NB;
      S_PATH:      state_next = (p_cell == s_cell || &plen) ? S_RESULT : S_PATH_RD;
      S_PATH_RD:   state_next = S_PATH;
      S_RESULT:    if (slot_free) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // Memory, root and queue control.
  always_comb begin
    obst_we    = 1'b0;
    obst_waddr = clr_idx;
    obst_wdata = 1'b0;
    node_we    = 1'b0;
    node_waddr = clr_idx;
    node_wdata = '0;
    node_raddr = nb_raddr;
    path_we    = 1'b0;
    path_waddr = plen;
    path_wdata = '{x: px, y: py};
    path_raddr = req_word.path_pos;
    root_start = 1'b0;
    root_dx    = absd(vx, gx);
    root_dy    = absd(vy, gy);
    hreq       = '0;
    hreq.key   = '{prio: sat_add(nc, COST_W'(root)), idx: v_cell};
    case (state)
      S_CLR: obst_we = 1'b1;
      S_IDLE: begin
        if (accept && req_word.cmd == CMD_LOAD && ld_in) begin
          obst_we    = 1'b1;
          obst_waddr = ld_addr[CELL_W-1:0];
          obst_wdata = req_word.blocked;
        end
        if (accept && req_word.cmd == CMD_SEARCH && !out_grid && s_addr == g_addr) begin
          path_we    = 1'b1;
          path_waddr = '0;
          path_wdata = '{x: req_word.goal_x, y: req_word.goal_y};
        end
      end
      S_NCLR: node_we = 1'b1;
      S_SEED: begin
        node_we    = 1'b1;
        node_waddr = s_cell;
        node_wdata = '{valid: 1'b1, cost: '0, parent: s_cell, x: sx, y: sy};
        root_start = 1'b1;
        root_dx    = absd(sx, gx);
        root_dy    = absd(sy, gy);
        hreq.clear = 1'b1;
      end
      S_ROOT_WAIT: begin
        hreq.push = root_done;
        hreq.key  = '{prio: COST_W'(root), idx: s_cell};
      end
      S_POP:      hreq.pop = !hrsp.busy && (hrsp.count != '0);
      S_POP_WAIT: node_raddr = hrsp.top.idx;
      S_NB_CHK: begin
        if (relax) begin
          node_we    = 1'b1;
          node_waddr = v_cell;
          node_wdata = '{valid: 1'b1, cost: nc, parent: u_cell, x: vx, y: vy};
          root_start = (v_cell != g_cell) && !q_full;
        end
      end
      S_H_WAIT: hreq.push = root_done;
      S_PATH: begin
        path_we = 1'b1;
        if (p_cell == s_cell || &plen) path_wdata = '{x: sx, y: sy};
        node_raddr = p_par;
      end
      default: ;
    endcase
  end

  // State and working registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLR;
      clr_idx       <= '0;
      stored_length <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_CLR:  clr_idx <= clr_idx + 1'b1;
        S_IDLE: begin
          if (accept) begin
            res <= res_new;
            sx  <= req_word.cell_x;
            sy  <= req_word.cell_y;
            gx  <= req_word.goal_x;
            gy  <= req_word.goal_y;
            s_cell  <= s_addr[CELL_W-1:0];
            g_cell  <= g_addr[CELL_W-1:0];
            clr_idx <= '0;
            if (req_word.cmd == CMD_SEARCH) stored_length <= res_new.path_length;
          end
        end
        S_READ: begin
          res.path_x <= path_rdata.x;
          res.path_y <= path_rdata.y;
        end
        S_NCLR: clr_idx <= clr_idx + 1'b1;
        S_POP: begin
          if (!hrsp.busy && hrsp.count == '0) res.status <= ST_NO_PATH;
        end
        S_POP_WAIT: u_cell <= hrsp.top.idx;
        S_UREAD: begin
          u_cost <= node_rdata.cost;
          ux     <= node_rdata.x;
          uy     <= node_rdata.y;
          k      <= '0;
        end
        S_NB: begin
          v_cell <= nb_raddr;
          vx     <= ux + dxk;
          vy     <= uy + dyk;
          if (nb_skip) k <= k + 1'b1;
        end
        S_NB_CHK: begin
          if (!relax) k <= k + 1'b1;
          else if (v_cell == g_cell) begin
            p_cell <= g_cell;
            px     <= gx;
            py     <= gy;
            p_par  <= u_cell;
            plen   <= '0;
          end else if (q_full) res.status <= ST_OVERFLOW;
        end
        S_PUSH_WAIT: if (!hrsp.busy) k <= k + 1'b1;
        S_PATH: begin
          if (p_cell == s_cell || &plen) begin
            stored_length   <= {1'b0, plen} + 1'b1;
            res.path_length <= {1'b0, plen} + 1'b1;
          end else begin
            plen <= plen + 1'b1;
          end
        end
        S_PATH_RD: begin
          p_cell <= p_par;
          px     <= node_rdata.x;
          py     <= node_rdata.y;
          p_par  <= node_rdata.parent;
        end
        default: ;
      endcase
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == S_RESULT && slot_free) begin
      rsp_valid <= 1'b1;
      rsp_word  <= res;
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    hreq.push |-> !hrsp.busy && !q_full)
    else $error("push into a busy or full queue");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    hreq.pop |-> !hrsp.busy && hrsp.count != '0)
    else $error("pop from a busy or empty queue");

  a_badpos_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_word.status == ST_BAD_POS |->
      rsp_word.path_x == '0 && rsp_word.path_y == '0)
    else $error("bad position word carries coordinates");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    stored_length <= LEN_W'(MAX_CELLS))
    else $error("stored path length beyond buffer");

endmodule

// ----- sv/gas_isqrt.sv -----
`timescale 1ns / 1ps

// Rounded square root of (dx*dx + dy*dy) * 65536, one result bit per cycle.
module gas_isqrt
  import gas_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [COORD_W-1:0] dx,
  input  logic [COORD_W-1:0] dy,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  localparam int RAD_W = 32;
  localparam int ITER  = RAD_W / 2;
  localparam int CNT_W = $clog2(ITER);

  logic [2*COORD_W-1:0] sqx, sqy;
  logic [2*COORD_W:0]   sumsq;
  logic [RAD_W-1:0]     rem, acc, bitv, trial;
  logic [CNT_W-1:0]     iter;
  logic                 run, fin;

  assign sqx   = dx * dx;
  assign sqy   = dy * dy;
  assign sumsq = {1'b0, sqx} + {1'b0, sqy};
  assign trial = acc + bitv;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      // Done pulses in the cycle after the rounding step.
      done <= fin && !start && !run;
      if (start) begin
        rem  <= RAD_W'({sumsq, 16'd0});
        acc  <= '0;
        bitv <= RAD_W'(1) << (RAD_W - 2);
        iter <= '0;
        run  <= 1'b1;
      end else if (run) begin
        // One restoring digit step.
        if (rem >= trial) begin
          rem <= rem - trial;
          acc <= (acc >> 1) + bitv;
        end else begin
          acc <= acc >> 1;
        end
        bitv <= bitv >> 2;
        iter <= iter + 1'b1;
        if (iter == CNT_W'(ITER - 1)) begin
          run <= 1'b0;
          fin <= 1'b1;
        end
      end else if (fin) begin
        // Round to nearest from the remainder.
        root <= (rem > acc) ? ROOT_W'(acc + 1'b1) : acc[ROOT_W-1:0];
        fin  <= 1'b0;
      end
    end
  end

endmodule

// ----- sv/gas_heap.sv -----
`timescale 1ns / 1ps

// Binary min-heap of open nodes in one memory, sifted level by level.
module gas_heap
  import gas_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  gas_heap_req_t req,
  output gas_heap_rsp_t rsp
);

  gas_heap_state_t   state, state_next;
  gas_key_t          heap_mem [QUEUE_DEPTH];
  gas_key_t          rdata, wdata, key, top, best;
  logic [QIDX_W-1:0] raddr, waddr, idx, par, best_idx;
  logic              we;
  logic [QCNT_W-1:0] cnt, child, sib;

  assign child = {idx, 1'b1};
  assign sib   = child + 1'b1;

  // Queue memory.
  always_ff @(posedge clk) begin
    if (we) heap_mem[waddr] <= wdata;
    rdata <= heap_mem[raddr];
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      H_IDLE: begin
        if (req.clear) state_next = H_IDLE;
        else if (req.push) state_next = H_UP_LOOP;
        else if (req.pop) state_next = H_DN_TOP;
      end
      H_UP_LOOP:  state_next = (idx == '0) ? H_IDLE : H_UP_CMP;
      H_UP_CMP:   state_next = (rdata <= key) ? H_IDLE : H_UP_LOOP;
      H_DN_TOP:   state_next = H_DN_LAST;
      H_DN_LAST:  state_next = H_DN_LOOP;
      H_DN_LOOP:  state_next = (child >= cnt) ? H_DN_FIN : H_DN_CHILD;
      H_DN_CHILD: state_next = (sib < cnt) ? H_DN_SIB : H_DN_MOVE;
      H_DN_SIB:   state_next = H_DN_MOVE;
      H_DN_MOVE:  state_next = (best >= key) ? H_DN_FIN : H_DN_LOOP;
      H_DN_FIN:   state_next = H_IDLE;
      default:    state_next = H_IDLE;
    endcase
  end

  // Memory port control.
  always_comb begin
    raddr = '0;
    we    = 1'b0;
    waddr = idx;
    wdata = key;
    case (state)
      H_UP_LOOP: begin
        if (idx == '0) we = 1'b1;
        else raddr = (idx - 1'b1) >> 1;
      end
      H_UP_CMP: begin
        we    = 1'b1;
        wdata = (rdata <= key) ? key : rdata;
      end
      // The count is already reduced, so it addresses the last entry.
      H_DN_TOP:   raddr = cnt[QIDX_W-1:0];
      H_DN_LOOP:  raddr = child[QIDX_W-1:0];
      H_DN_CHILD: raddr = sib[QIDX_W-1:0];
      H_DN_MOVE: begin
        we    = !(best >= key);
        wdata = best;
      end
      H_DN_FIN:   we = (cnt != '0);
      default:    raddr = '0;
    endcase
  end

  // State and working registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= H_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      case (state)
        H_IDLE: begin
          if (req.clear) begin
            cnt <= '0;
          end else if (req.push) begin
            idx <= cnt[QIDX_W-1:0];
            cnt <= cnt + 1'b1;
            key <= req.key;
          end else if (req.pop) begin
            cnt <= cnt - 1'b1;
          end
        end
        H_UP_LOOP: par <= (idx - 1'b1) >> 1;
        H_UP_CMP:  idx <= par;
        H_DN_TOP:  top <= rdata;
        H_DN_LAST: begin
          key <= rdata;
          idx <= '0;
        end
        H_DN_CHILD: begin
          best     <= rdata;
          best_idx <= child[QIDX_W-1:0];
        end
        H_DN_SIB: begin
          if (rdata < best) begin
            best     <= rdata;
            best_idx <= sib[QIDX_W-1:0];
          end
        end
        H_DN_MOVE: if (!(best >= key)) idx <= best_idx;
        default: ;
      endcase
    end
  end

  assign rsp.busy  = (state != H_IDLE);
  assign rsp.count = cnt;
  assign rsp.top   = top;

endmodule
